### rtl/core/ac_ir_frame_encoder_216bit_macros.svh
// Assertion macros for the infrared frame encoder.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef AC_IR_FRAME_ENCODER_216BIT_MACROS_SVH
`define AC_IR_FRAME_ENCODER_216BIT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ACIR_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("acir same-cycle check failed");

// Next-cycle implication, disabled during reset
`define ACIR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("acir next-cycle check failed");

`endif

### rtl/core/acir_pkg.sv
// Shared constants of the infrared frame encoder: byte template, code tables,
// symbol timings and symbol sequence positions. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package acir_pkg;

  localparam int unsigned FRAME_LEN = 27;

  typedef logic [7:0] byte_t;
  typedef logic [4:0] sym_idx_t;
  typedef logic [4:0] byte_idx_t;

  // Fixed frame template; command bytes and checksums are overlaid in the encoder
  localparam byte_t FRAME_TEMPLATE [FRAME_LEN] = '{
    8'h11, 8'hDA, 8'h27, 8'hF0, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h11, 8'hDA, 8'h27, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hC0,
    8'h00, 8'h00, 8'h00
  };

  localparam logic [2:0] MODE_CODES [5] = '{3'd0, 3'd3, 3'd4, 3'd2, 3'd6};
  localparam logic [3:0] FAN_CODES  [4] = '{4'd10, 4'd3, 4'd5, 4'd7};

  // Temperature saturation bounds
  localparam logic [5:0] TEMP_MIN = 6'd10;
  localparam logic [5:0] TEMP_MAX = 6'd32;
  localparam logic [2:0] MODE_MAX = 3'd4;

  // Pair timings in microseconds
  localparam logic [11:0] HDR_MARK  = 12'd3440;
  localparam logic [14:0] HDR_SPACE = 15'd1750;
  localparam logic [11:0] GAP_MARK  = 12'd420;
  localparam logic [14:0] GAP_SPACE = 15'd29650;

  // Symbol kinds
  localparam logic KIND_PAIR = 1'b0;
  localparam logic KIND_BYTE = 1'b1;

  // Positions in the 31-symbol sequence
  localparam sym_idx_t SYM_HDR1  = 5'd0;
  localparam sym_idx_t SYM_GAP1  = 5'd9;
  localparam sym_idx_t SYM_HDR2  = 5'd10;
  localparam sym_idx_t SYM_LAST  = 5'd30;
  localparam sym_idx_t SEG1_OFS  = 5'd1;
  localparam sym_idx_t SEG2_OFS  = 5'd3;

  // Frame byte positions that carry command fields or checksums
  localparam byte_idx_t BYTE_SUM1  = 5'd7;
  localparam byte_idx_t BYTE_MODE  = 5'd13;
  localparam byte_idx_t BYTE_TEMP  = 5'd14;
  localparam byte_idx_t BYTE_FAN   = 5'd16;
  localparam byte_idx_t BYTE_SWING = 5'd17;
  localparam byte_idx_t BYTE_SUM2  = 5'd26;

endpackage

`default_nettype wire

### rtl/core/ac_ir_frame_encoder_216bit.sv
// Infrared frame encoder top level: symbol sequencer with one shared byte adder.
// Depends on acir_pkg and ac_ir_frame_encoder_216bit_macros.svh.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------------------
//  in      | to block  | in_valid / in_stall   | power_on, temperature, mode_index,
//          |           |                       | fan_index, swing_horizontal, swing_vertical
//  out     | from block| out_valid / out_stall | symbol_kind, mark_us, space_us,
//          |           |                       | data_byte, last_symbol
//
// A command is captured in the idle state; the sequencer then moves its 31 symbols
// into the output register at one per cycle while the output is not stalled.
// The checksums come from one 8-bit adder that sums frame bytes as they leave.
// in_stall stays high while the sequencer runs; out_stall freezes the sequencer.
// Synchronous reset clears the sequencer and the output valid; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

`include "ac_ir_frame_encoder_216bit_macros.svh"

module ac_ir_frame_encoder_216bit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        power_on,
  input  wire logic [5:0]  temperature,
  input  wire logic [2:0]  mode_index,
  input  wire logic [1:0]  fan_index,
  input  wire logic        swing_horizontal,
  input  wire logic        swing_vertical,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             symbol_kind,
  output logic [11:0]      mark_us,
  output logic [14:0]      space_us,
  output logic [7:0]       data_byte,
  output logic             last_symbol
);
  import acir_pkg::*;

  typedef enum logic {ST_IDLE, ST_RUN} state_t;

  state_t   state;
  sym_idx_t sym;
  byte_t    acc;
  byte_t    b_mode, b_temp, b_fan, b_swing;

  logic       accept;
  logic       load;
  logic [5:0] temp_sat;
  logic [2:0] mode_sel;
  byte_idx_t  byte_idx;
  byte_t      frame_byte;
  byte_t      acc_sum;
  logic       kind_c;
  logic [11:0] mark_c;
  logic [14:0] space_c;
  byte_t      byte_c;
  logic       last_c;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign load     = (state == ST_RUN) && (!out_valid || !out_stall);

  // Saturate temperature and fold unused mode codes onto mode 0
  always_comb begin
    if (temperature < TEMP_MIN) begin
      temp_sat = TEMP_MIN;
    end else if (temperature > TEMP_MAX) begin
      temp_sat = TEMP_MAX;
    end else begin
      temp_sat = temperature;
    end
    mode_sel = (mode_index > MODE_MAX) ? 3'd0 : mode_index;
  end

  // Map sequence position to frame byte position
  always_comb begin
    if (sym <= SYM_GAP1) begin
      byte_idx = sym - SEG1_OFS;
    end else begin
      byte_idx = sym - SEG2_OFS;
    end
  end

  // Select the frame byte: checksum, command byte or template
  always_comb begin
    unique case (byte_idx)
      BYTE_SUM1, BYTE_SUM2: frame_byte = acc;
      BYTE_MODE:            frame_byte = b_mode;
      BYTE_TEMP:            frame_byte = b_temp;
      BYTE_FAN:             frame_byte = b_fan;
      BYTE_SWING:           frame_byte = b_swing;
      default:              frame_byte = FRAME_TEMPLATE[byte_idx];
    endcase
  end

  // Shared checksum adder
  assign acc_sum = acc + byte_c;

  // Build the next symbol
  always_comb begin
    kind_c  = KIND_BYTE;
    mark_c  = '0;
    space_c = '0;
    byte_c  = '0;
    last_c  = 1'b0;
    unique case (sym)
      SYM_HDR1, SYM_HDR2: begin
        kind_c  = KIND_PAIR;
        mark_c  = HDR_MARK;
        space_c = HDR_SPACE;
      end
      SYM_GAP1, SYM_LAST: begin
        kind_c  = KIND_PAIR;
        mark_c  = GAP_MARK;
        space_c = GAP_SPACE;
        last_c  = (sym == SYM_LAST);
      end
      default: begin
        byte_c = frame_byte;
      end
    endcase
  end

  // Sequencer state, command bytes, checksum and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      sym       <= SYM_HDR1;
      acc       <= '0;
      out_valid <= 1'b0;
    end else begin
      // Drop the output once taken unless a new symbol loads behind it
      if (out_valid && !out_stall && !load) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            b_mode  <= {1'b0, MODE_CODES[mode_sel], 3'b000, power_on};
            b_temp  <= {1'b0, temp_sat, 1'b0};
            b_fan   <= {FAN_CODES[fan_index], {4{swing_vertical}}};
            b_swing <= {4'h0, {4{swing_horizontal}}};
            sym     <= SYM_HDR1;
            state   <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (load) begin
            out_valid   <= 1'b1;
            symbol_kind <= kind_c;
            mark_us     <= mark_c;
            space_us    <= space_c;
            data_byte   <= byte_c;
            last_symbol <= last_c;
            // Restart the sum at each header, accumulate on data bytes
            if (sym == SYM_HDR1 || sym == SYM_HDR2) begin
              acc <= '0;
            end else if (kind_c == KIND_BYTE) begin
              acc <= acc_sum;
            end
            if (sym == SYM_LAST) begin
              state <= ST_IDLE;
            end else begin
              sym <= sym + 5'd1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `ACIR_ASSERT_NEXT(a_accept_starts, clk, rst, accept, (state == ST_RUN) && (sym == SYM_HDR1))
  `ACIR_ASSERT_NOW(a_sym_range, clk, rst, state == ST_RUN, sym <= SYM_LAST)
  `ACIR_ASSERT_NEXT(a_last_ends, clk, rst, load && (sym == SYM_LAST), state == ST_IDLE)
  `ACIR_ASSERT_NOW(a_byte_no_timing, clk, rst, out_valid && (symbol_kind == KIND_BYTE),
                   (mark_us == 12'd0) && (space_us == 15'd0) && !last_symbol)

endmodule

`default_nettype wire
